FILE: hdl/rtc_pkg.sv
// ---------------------------------------------------------------------------
// rtc_pkg
// Shared beat types, operation codes and register map of the real-time
// counter peripheral.
// ---------------------------------------------------------------------------
package rtc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned INDEX_W   = 5;
	localparam int unsigned CMP_OUT_W = 4;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	localparam logic [INDEX_W-1:0] REG_TASK_START = 5'd0;
	localparam logic [INDEX_W-1:0] REG_TASK_STOP  = 5'd1;
	localparam logic [INDEX_W-1:0] REG_TASK_CLEAR = 5'd2;
	localparam logic [INDEX_W-1:0] REG_TASK_OVF   = 5'd3;
	localparam logic [INDEX_W-1:0] REG_EVT_TICK   = 5'd4;
	localparam logic [INDEX_W-1:0] REG_EVT_LAST   = 5'd9;
	localparam logic [INDEX_W-1:0] REG_INTEN      = 5'd10;
	localparam logic [INDEX_W-1:0] REG_INTENSET   = 5'd11;
	localparam logic [INDEX_W-1:0] REG_INTENCLR   = 5'd12;
	localparam logic [INDEX_W-1:0] REG_EVTEN      = 5'd13;
	localparam logic [INDEX_W-1:0] REG_EVTENSET   = 5'd14;
	localparam logic [INDEX_W-1:0] REG_EVTENCLR   = 5'd15;
	localparam logic [INDEX_W-1:0] REG_COUNTER    = 5'd16;
	localparam logic [INDEX_W-1:0] REG_PRESCALER  = 5'd17;
	localparam logic [INDEX_W-1:0] REG_CC0        = 5'd18;
	localparam logic [INDEX_W-1:0] REG_CC_LAST    = 5'd21;

	// enable bit positions in INTEN and EVTEN
	localparam int unsigned EN_TICK_BIT = 0;
	localparam int unsigned EN_OVF_BIT  = 1;
	localparam int unsigned EN_CMP_BIT  = 16;

	typedef struct packed {
		op_t                operation;
		logic [INDEX_W-1:0] reg_index;
		logic [DATA_W-1:0]  write_data;
	} rtc_in_t;

	typedef struct packed {
		logic [DATA_W-1:0]    read_data;
		logic                 irq;
		logic                 tick_pulse;
		logic                 overflow_pulse;
		logic [CMP_OUT_W-1:0] compare_pulses;
	} rtc_out_t;

endpackage

FILE: hdl/rtc_counter_compare_peripheral_core.sv
// ---------------------------------------------------------------------------
// rtc_counter_compare_peripheral_core
// Low-frequency real-time counter with prescaler, compare channels, event
// routing and interrupt, driven by register beats and clock-tick beats.
// ---------------------------------------------------------------------------
// a result beat is registered into the output queue when its input beat is taken
// throughput: one beat per cycle while the output queue is not full; register update and result are one pass
// a two-entry output queue keeps input open while a result waits
// reset: counter stopped, all registers, events and enables cleared
module rtc_counter_compare_peripheral_core #(
	parameter int unsigned CHANNELS       = 4,
	parameter int unsigned COUNTER_BITS   = 24,
	parameter int unsigned PRESCALER_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rtc_pkg::rtc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rtc_pkg::rtc_out_t out_data
);
	import rtc_pkg::*;

	localparam int unsigned EW = 2 + CHANNELS;
	localparam logic [COUNTER_BITS-1:0] OVF_LOAD =
		{COUNTER_BITS{1'b1}} - COUNTER_BITS'(15);

	logic [COUNTER_BITS-1:0]   count_q, count_n;
	logic [PRESCALER_BITS-1:0] presc_q, presc_n;
	logic [PRESCALER_BITS-1:0] phase_q, phase_n;
	logic                      running_q, running_n;
	logic [EW-1:0]             evt_q, evt_n;
	logic [DATA_W-1:0]         inten_q, inten_n;
	logic [DATA_W-1:0]         evten_q, evten_n;
	logic [COUNTER_BITS-1:0]   cmp_q [CHANNELS];
	logic [COUNTER_BITS-1:0]   cmp_n [CHANNELS];

	logic                      in_acc;
	rtc_out_t                  res;
	logic [2:0]                ev_sel;
	logic [1:0]                cc_sel;
	logic [COUNTER_BITS-1:0]   cnt_inc;
	logic [DATA_W-1:0]         wd;
	logic [DATA_W-1:0]         flag_mask;

	logic [1:0]                lvl_q, lvl_pop;
	logic                      pop;
	rtc_out_t                  e0_q, e1_q;

	assign in_acc  = in_valid && in_ready;
	assign ev_sel  = 3'(in_data.reg_index - REG_EVT_TICK);
	assign cc_sel  = 2'(in_data.reg_index - REG_CC0);
	assign cnt_inc = count_q + COUNTER_BITS'(1);
	assign wd      = in_data.write_data;

	always_comb begin
		count_n   = count_q;
		presc_n   = presc_q;
		phase_n   = phase_q;
		running_n = running_q;
		evt_n     = evt_q;
		inten_n   = inten_q;
		evten_n   = evten_q;
		cmp_n     = cmp_q;
		res       = '0;
		if (in_acc) begin
			unique case (in_data.operation)
				OP_READ: begin
					case (in_data.reg_index) inside
						[REG_EVT_TICK:REG_EVT_LAST]: begin
							for (int j = 0; j < EW; j++) begin
								if (ev_sel == 3'(j)) res.read_data = DATA_W'(evt_q[j]);
							end
						end
						[REG_INTEN:REG_INTENCLR]: res.read_data = inten_q;
						[REG_EVTEN:REG_EVTENCLR]: res.read_data = evten_q;
						REG_COUNTER: res.read_data = DATA_W'(count_q);
						REG_PRESCALER: res.read_data = DATA_W'(presc_q);
						[REG_CC0:REG_CC_LAST]: begin
							for (int c = 0; c < CHANNELS; c++) begin
								if (cc_sel == 2'(c)) res.read_data = DATA_W'(cmp_q[c]);
							end
						end
						default: ;
					endcase
				end
				OP_WRITE: begin
					case (in_data.reg_index) inside
						REG_TASK_START: begin
							if (wd != '0) begin
								running_n = 1'b1;
								phase_n   = '0;
							end
						end
						REG_TASK_STOP: if (wd != '0) running_n = 1'b0;
						REG_TASK_CLEAR: if (wd != '0) count_n = '0;
						REG_TASK_OVF: if (wd != '0) count_n = OVF_LOAD;
						[REG_EVT_TICK:REG_EVT_LAST]: begin
							for (int j = 0; j < EW; j++) begin
								if (ev_sel == 3'(j)) evt_n[j] = (wd != '0);
							end
						end
						REG_INTEN: inten_n = wd;
						REG_INTENSET: inten_n = inten_q | wd;
						REG_INTENCLR: inten_n = inten_q & ~wd;
						REG_EVTEN: evten_n = wd;
						REG_EVTENSET: evten_n = evten_q | wd;
						REG_EVTENCLR: evten_n = evten_q & ~wd;
						REG_COUNTER: count_n = wd[COUNTER_BITS-1:0];
						REG_PRESCALER: if (!running_q) presc_n = wd[PRESCALER_BITS-1:0];
						[REG_CC0:REG_CC_LAST]: begin
							for (int c = 0; c < CHANNELS; c++) begin
								if (cc_sel == 2'(c)) cmp_n[c] = wd[COUNTER_BITS-1:0];
							end
						end
						default: ;
					endcase
				end
				OP_TICK: begin
					if (running_q) begin
						if (phase_q < presc_q) begin
							phase_n = phase_q + PRESCALER_BITS'(1);
						end else begin
							phase_n = '0;
							count_n = cnt_inc;
							if (cnt_inc == '0) begin
								evt_n[1]           = 1'b1;
								res.overflow_pulse = evten_q[EN_OVF_BIT];
							end
							evt_n[0]       = 1'b1;
							res.tick_pulse = evten_q[EN_TICK_BIT];
							for (int c = 0; c < CHANNELS; c++) begin
								if (!evt_q[2+c] && cmp_q[c] != '0 && cmp_q[c] == cnt_inc) begin
									evt_n[2+c]            = 1'b1;
									res.compare_pulses[c] = evten_q[EN_CMP_BIT+c];
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
		flag_mask = '0;
		flag_mask[EN_TICK_BIT] = evt_n[0];
		flag_mask[EN_OVF_BIT]  = evt_n[1];
		for (int c = 0; c < CHANNELS; c++) begin
			flag_mask[EN_CMP_BIT+c] = evt_n[2+c];
		end
		res.irq = |(flag_mask & inten_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			presc_q   <= '0;
			phase_q   <= '0;
			running_q <= 1'b0;
			evt_q     <= '0;
			inten_q   <= '0;
			evten_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				cmp_q[c] <= '0;
			end
		end else if (in_acc) begin
			count_q   <= count_n;
			presc_q   <= presc_n;
			phase_q   <= phase_n;
			running_q <= running_n;
			evt_q     <= evt_n;
			inten_q   <= inten_n;
			evten_q   <= evten_n;
			cmp_q     <= cmp_n;
		end
	end

	// two-entry output queue, head in e0_q
	assign pop       = (lvl_q != 2'd0) && out_ready;
	assign lvl_pop   = lvl_q - 2'(pop);
	assign in_ready  = (lvl_q != 2'd2);
	assign out_valid = (lvl_q != 2'd0);
	assign out_data  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else begin
			lvl_q <= lvl_pop + 2'(in_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && lvl_q == 2'd2) e0_q <= e1_q;
		if (in_acc) begin
			if (lvl_pop == 2'd0) e0_q <= res;
			else e1_q <= res;
		end
	end

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q != 2'd3)
		else $error("output queue level out of range");

	a_stopped_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !running_q && in_data.operation == OP_TICK |=> $stable(count_q))
		else $error("counter moved while stopped");

	a_presc_lock: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && running_q && in_data.operation == OP_WRITE
		&& in_data.reg_index == REG_PRESCALER |=> $stable(presc_q))
		else $error("prescaler changed while running");

	a_pulse_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.operation != OP_TICK |-> !res.tick_pulse
		&& !res.overflow_pulse && res.compare_pulses == '0)
		else $error("event pulse outside a tick beat");

endmodule

FILE: tb/tb_rtc_counter_compare_peripheral_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rtc_counter_compare_peripheral_core
// Self-checking bench for the real-time counter core. A queue-fed driver
// offers register and tick beats in bursts, a monitor takes result beats
// under a changing stall pattern, and a cycle-free model of the counter,
// prescaler, compare channels, events and enables predicts every result.
// A directed pass covers the limits and corner cases, then random
// register sessions run the counter through wraps and compare matches.
// ---------------------------------------------------------------------------
module tb_rtc_counter_compare_peripheral_core;

	import rtc_pkg::*;

	localparam int NUM_CH = 4;
	localparam int CNT_W  = 24;
	localparam int PRE_W  = 12;
	localparam logic [CNT_W-1:0] OVF_PRELOAD = 24'hFFFFF0;
	localparam int EVT_TICK = 0;
	localparam int EVT_OVF  = 1;
	localparam int EVT_CMP0 = 2;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	rtc_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	rtc_out_t out_data;

	rtc_counter_compare_peripheral_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// model state
	logic [CNT_W-1:0] cnt_m;
	logic [PRE_W-1:0] presc_m;
	logic [PRE_W-1:0] phase_m;
	logic             running_m;
	logic [5:0]       evt_m;
	logic [31:0]      inten_m;
	logic [31:0]      evten_m;
	logic [CNT_W-1:0] cc_m [NUM_CH];

	rtc_in_t  beat_q [$];
	rtc_out_t result_q [$];

	int n_beats_queued = 0;
	int n_reads = 0, n_writes = 0, n_ticks = 0;
	int n_advances = 0, n_wraps = 0, n_matches = 0, n_irq_high = 0;
	int n_results = 0;
	int err_cnt = 0;

	int burst_left, gap_left;
	int hold_left, mode_left, rx_beats, next_hold_at;
	logic [7:0] ready_pat;

	initial forever #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_rtc_counter_compare_peripheral_core failed");
		$finish;
	end

	task automatic counter_step(input rtc_in_t b, output rtc_out_t r);
		logic [31:0] wd;
		logic [31:0] evt_bits;
		int e;
		wd = b.write_data;
		r = '0;
		case (b.operation)
			OP_READ: begin
				n_reads++;
				if (b.reg_index >= REG_EVT_TICK && b.reg_index <= REG_EVT_LAST) begin
					e = int'(b.reg_index - REG_EVT_TICK);
					r.read_data = 32'(evt_m[e]);
				end else if (b.reg_index >= REG_INTEN && b.reg_index <= REG_INTENCLR) begin
					r.read_data = inten_m;
				end else if (b.reg_index >= REG_EVTEN && b.reg_index <= REG_EVTENCLR) begin
					r.read_data = evten_m;
				end else if (b.reg_index == REG_COUNTER) begin
					r.read_data = 32'(cnt_m);
				end else if (b.reg_index == REG_PRESCALER) begin
					r.read_data = 32'(presc_m);
				end else if (b.reg_index >= REG_CC0 && b.reg_index <= REG_CC_LAST) begin
					r.read_data = 32'(cc_m[2'(b.reg_index - REG_CC0)]);
				end
			end
			OP_WRITE: begin
				n_writes++;
				case (b.reg_index)
					REG_TASK_START: if (wd != 0) begin
						running_m = 1'b1;
						phase_m = '0;
					end
					REG_TASK_STOP:  if (wd != 0) running_m = 1'b0;
					REG_TASK_CLEAR: if (wd != 0) cnt_m = '0;
					REG_TASK_OVF:   if (wd != 0) cnt_m = OVF_PRELOAD;
					REG_INTEN:      inten_m = wd;
					REG_INTENSET:   inten_m = inten_m | wd;
					REG_INTENCLR:   inten_m = inten_m & ~wd;
					REG_EVTEN:      evten_m = wd;
					REG_EVTENSET:   evten_m = evten_m | wd;
					REG_EVTENCLR:   evten_m = evten_m & ~wd;
					REG_COUNTER:    cnt_m = wd[CNT_W-1:0];
					REG_PRESCALER:  if (!running_m) presc_m = wd[PRE_W-1:0];
					default: begin
						if (b.reg_index >= REG_EVT_TICK && b.reg_index <= REG_EVT_LAST)
							evt_m[3'(b.reg_index - REG_EVT_TICK)] = (wd != 0);
						else if (b.reg_index >= REG_CC0 && b.reg_index <= REG_CC_LAST)
							cc_m[2'(b.reg_index - REG_CC0)] = wd[CNT_W-1:0];
					end
				endcase
			end
			OP_TICK: begin
				n_ticks++;
				if (running_m) begin
					if (phase_m < presc_m) begin
						phase_m = phase_m + 1'b1;
					end else begin
						phase_m = '0;
						cnt_m = cnt_m + 1'b1;
						n_advances++;
						if (cnt_m == 0) begin
							evt_m[EVT_OVF] = 1'b1;
							r.overflow_pulse = evten_m[EN_OVF_BIT];
							n_wraps++;
						end
						evt_m[EVT_TICK] = 1'b1;
						r.tick_pulse = evten_m[EN_TICK_BIT];
						for (int i = 0; i < NUM_CH; i++) begin
							if (!evt_m[EVT_CMP0+i] && cc_m[i] != 0 && cc_m[i] == cnt_m) begin
								evt_m[EVT_CMP0+i] = 1'b1;
								r.compare_pulses[i] = evten_m[EN_CMP_BIT+i];
								n_matches++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		evt_bits = '0;
		evt_bits[EN_TICK_BIT] = evt_m[EVT_TICK];
		evt_bits[EN_OVF_BIT] = evt_m[EVT_OVF];
		for (int i = 0; i < NUM_CH; i++)
			evt_bits[EN_CMP_BIT+i] = evt_m[EVT_CMP0+i];
		r.irq = |(evt_bits & inten_m);
		if (r.irq)
			n_irq_high++;
	endtask

	task automatic add_beat(input op_t op, input logic [INDEX_W-1:0] idx,
			input logic [DATA_W-1:0] d);
		rtc_in_t b;
		b.operation = op;
		b.reg_index = idx;
		b.write_data = d;
		beat_q.push_back(b);
		n_beats_queued++;
	endtask

	function automatic logic [31:0] any_nonzero();
		logic [31:0] w;
		w = ($urandom_range(0, 2) == 0) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
		if (w == 0)
			w = 32'h1;
		return w;
	endfunction

	// stop, load prescaler, counter, compares and enables, start, then run
	task automatic add_session();
		logic [CNT_W-1:0] base;
		int n;
		add_beat(OP_WRITE, REG_TASK_STOP, any_nonzero());
		add_beat(OP_WRITE, REG_PRESCALER,
			($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3));
		base = ($urandom_range(0, 2) == 0) ? CNT_W'(OVF_PRELOAD + $urandom_range(0, 15))
			: CNT_W'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			base = OVF_PRELOAD;
			add_beat(OP_WRITE, REG_TASK_OVF, any_nonzero());
		end else begin
			add_beat(OP_WRITE, REG_COUNTER, {8'($urandom), base});
		end
		for (int i = 0; i < NUM_CH; i++) begin
			case ($urandom_range(0, 5))
				0: add_beat(OP_WRITE, REG_CC0 + INDEX_W'(i), {8'($urandom), 24'h0});
				1: ;
				default: add_beat(OP_WRITE, REG_CC0 + INDEX_W'(i),
					{8'($urandom), 24'(base + $urandom_range(0, 12))});
			endcase
		end
		add_beat(OP_WRITE, REG_INTEN + INDEX_W'($urandom_range(0, 2)), $urandom);
		add_beat(OP_WRITE, REG_EVTEN + INDEX_W'($urandom_range(0, 2)),
			($urandom_range(0, 1) == 0) ? ($urandom | 32'h000F0003) : $urandom);
		add_beat(OP_WRITE, REG_TASK_START, any_nonzero());
		n = $urandom_range(10, 40);
		repeat (n) begin
			case ($urandom_range(0, 9))
				6: add_beat(OP_READ, INDEX_W'($urandom_range(0, 21)), $urandom);
				7: add_beat(OP_WRITE, REG_EVT_TICK + INDEX_W'($urandom_range(0, 5)),
					($urandom_range(0, 3) == 0) ? any_nonzero() : 32'h0);
				8: add_beat(OP_WRITE, REG_INTEN + INDEX_W'($urandom_range(0, 5)), $urandom);
				9: begin
					case ($urandom_range(0, 5))
						0: add_beat(OP_WRITE, REG_PRESCALER, $urandom);
						1: add_beat(OP_WRITE, REG_TASK_CLEAR, any_nonzero());
						2: add_beat(OP_WRITE, REG_TASK_OVF, any_nonzero());
						3: add_beat(OP_WRITE, REG_TASK_STOP, any_nonzero());
						4: add_beat(OP_WRITE, REG_TASK_START,
							($urandom_range(0, 1) == 0) ? 32'h0 : any_nonzero());
						default: add_beat(OP_READ, REG_COUNTER, $urandom);
					endcase
				end
				default: add_beat(OP_TICK, INDEX_W'($urandom_range(0, 31)), $urandom);
			endcase
		end
	endtask

	task automatic add_noise();
		op_t op;
		op = ($urandom_range(0, 15) == 0) ? op_t'(2'd3) : op_t'($urandom_range(0, 2));
		add_beat(op,
			($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 31))
				: INDEX_W'($urandom_range(0, 21)),
			($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
	endtask

	task automatic wait_drained();
		while (beat_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		cnt_m = '0;
		presc_m = '0;
		phase_m = '0;
		running_m = 1'b0;
		evt_m = '0;
		inten_m = '0;
		evten_m = '0;
		for (int i = 0; i < NUM_CH; i++)
			cc_m[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: limits, ignored writes, wrap and compare corners
		add_beat(OP_READ,  REG_PRESCALER, 32'hFFFFFFFF);
		add_beat(OP_WRITE, REG_PRESCALER, 32'hFFFFFFFF);
		add_beat(OP_READ,  REG_PRESCALER, 32'h0);
		add_beat(OP_WRITE, REG_PRESCALER, 32'h0);
		add_beat(OP_WRITE, REG_EVTEN,     32'hFFFFFFFF);
		add_beat(OP_WRITE, REG_INTENSET,  32'h00000002);
		add_beat(OP_WRITE, REG_CC0,       32'hFFFFFFFF);
		add_beat(OP_WRITE, REG_CC0 + 5'd1, 32'h00000001);
		add_beat(OP_WRITE, REG_COUNTER,   32'hFFFFFFFE);
		add_beat(OP_WRITE, REG_TASK_START, 32'h80000000);
		add_beat(OP_WRITE, REG_PRESCALER, 32'h00000007);
		add_beat(OP_TICK,  REG_TASK_START, 32'h0);
		add_beat(OP_TICK,  REG_CC_LAST,   32'hFFFFFFFF);
		add_beat(OP_TICK,  5'd31,         32'h0);
		add_beat(OP_READ,  REG_EVT_TICK + 5'd1, 32'h0);
		add_beat(OP_WRITE, REG_EVT_TICK + 5'd1, 32'h0);
		add_beat(OP_WRITE, REG_TASK_START, 32'h0);
		add_beat(OP_WRITE, REG_TASK_OVF,  32'h00000001);
		add_beat(OP_READ,  REG_COUNTER,   32'h0);
		add_beat(OP_WRITE, REG_INTENCLR,  32'hFFFFFFFF);
		add_beat(OP_WRITE, REG_EVT_TICK,  32'h80000000);
		add_beat(OP_WRITE, REG_TASK_CLEAR, 32'hFFFFFFFF);
		add_beat(OP_WRITE, REG_TASK_STOP, 32'h00000001);
		add_beat(OP_TICK,  REG_TASK_STOP, 32'h0);
		add_beat(OP_READ,  REG_EVTENSET,  32'h0);
		add_beat(OP_WRITE, REG_EVTENCLR,  32'h00010001);
		add_beat(OP_READ,  5'd25,         32'h0);
		add_beat(op_t'(2'd3), REG_COUNTER, 32'hFFFFFFFF);
		wait_drained();

		while (n_beats_queued < 540) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			else
				add_session();
		end
		wait_drained();

		while (n_beats_queued < 1050) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			else
				add_session();
		end
		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d reads, %0d writes, %0d ticks (%0d counter advances)",
			n_reads, n_writes, n_ticks, n_advances);
		$display("%0d wraps, %0d compare matches, irq high after %0d beats, %0d results",
			n_wraps, n_matches, n_irq_high, n_results);
		if (err_cnt == 0)
			$display("tb_rtc_counter_compare_peripheral_core passed");
		else
			$display("tb_rtc_counter_compare_peripheral_core failed");
		$finish;
	end

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0 || beat_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				in_data <= beat_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: changing stall pattern plus long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
			rx_beats = 0;
			next_hold_at = 300;
			ready_pat = 8'hFF;
		end else begin
			if (out_valid && out_ready)
				rx_beats++;
			if (rx_beats >= next_hold_at) begin
				hold_left = 120;
				next_hold_at = next_hold_at + 500;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 80);
				ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
				if (ready_pat == 0)
					ready_pat = 8'h01;
			end else begin
				mode_left--;
			end
			ready_pat = {ready_pat[6:0], ready_pat[7]};
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ready_pat[0];
			end
		end
	end

	// prediction on input beats, comparison on result beats
	always @(posedge clk) begin
		rtc_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				counter_step(in_data, want);
				result_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (result_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected result beat %h", $realtime, out_data);
				end else begin
					want = result_q.pop_front();
					if (out_data.read_data !== want.read_data || out_data.irq !== want.irq ||
							out_data.tick_pulse !== want.tick_pulse ||
							out_data.overflow_pulse !== want.overflow_pulse ||
							out_data.compare_pulses !== want.compare_pulses) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: mismatch exp rd=%h irq=%b tick=%b ovf=%b cmp=%b",
								$realtime, want.read_data, want.irq, want.tick_pulse,
								want.overflow_pulse, want.compare_pulses);
							$display("%0t:          got rd=%h irq=%b tick=%b ovf=%b cmp=%b",
								$realtime, out_data.read_data, out_data.irq,
								out_data.tick_pulse, out_data.overflow_pulse,
								out_data.compare_pulses);
						end
					end
				end
			end
		end
	end

endmodule
